// ===== hdl/i2cbb_pkg.sv =====
// shared types, constants and phase tables for the i2c bit-bang phaser
package i2cbb_pkg;

  // default tag queue depth and command queue depth
  localparam int TAG_DEPTH_DEF = 64;
  localparam int CMDQ_DEPTH    = 4;
  localparam int BYTE_BITS     = 8;

  // bus actions
  typedef enum logic [2:0] {
    ACT_START  = 3'd0,
    ACT_RSTART = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_WRITE  = 3'd3,
    ACT_READ   = 3'd4,
    ACT_ACK    = 3'd5,
    ACT_SAMPLE = 3'd6
  } action_t;

  // meaning of a returned sda sample
  typedef enum logic [1:0] {
    TAG_IGNORE = 2'd0,
    TAG_DATA   = 2'd1,
    TAG_ACK    = 2'd2
  } tag_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PHASE  = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_REFUSE = 2'd2
  } kind_t;

  // class of a queued item
  typedef enum logic [1:0] {
    CLS_CMD    = 2'd0,
    CLS_SAMPLE = 2'd1,
    CLS_REFUSE = 2'd2
  } cls_t;

  // back sequencer states
  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_PHASE  = 2'd1,
    BK_SAMPLE = 2'd2
  } bk_state_t;

  // classified item between front and back
  typedef struct packed {
    cls_t       cls;
    action_t    action;
    logic [7:0] data;
    logic       ack;
    logic       sda;
    logic       hit;
  } entry_t;

  // front to back queue status
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } cmdq_t;

  // one pin phase
  typedef struct packed {
    logic sda;
    logic scl;
    tag_t tag;
    logic last;
  } phase_t;

  // phase count of a command
  function automatic logic [5:0] need_f(input logic [2:0] act);
    logic [5:0] n;
    n = 6'd0;
    case (act)
      ACT_START:  n = 6'd3;
      ACT_RSTART: n = 6'd4;
      ACT_STOP:   n = 6'd5;
      ACT_WRITE:  n = 6'd36;
      ACT_READ:   n = 6'd32;
      ACT_ACK:    n = 6'd4;
      default:    n = 6'd0;
    endcase
    return n;
  endfunction

  // pin levels, tag and last flag of phase idx of a command
  function automatic phase_t phase_f(input logic [2:0] act, input logic [7:0] data,
                                     input logic ack, input logic [5:0] idx);
    phase_t     p;
    logic       mid;
    logic [2:0] bsel;
    p    = '{sda: 1'b1, scl: 1'b0, tag: TAG_IGNORE, last: 1'b0};
    mid  = (idx[1:0] == 2'd1) || (idx[1:0] == 2'd2);
    bsel = 3'(3'd7 - idx[4:2]);
    case (act)
      ACT_START: begin
        p.sda  = 1'b0;
        p.scl  = (idx != 6'd2);
        p.last = (idx == 6'd2);
      end
      ACT_RSTART: begin
        p.sda  = (idx == 6'd0) || (idx == 6'd1);
        p.scl  = (idx == 6'd1) || (idx == 6'd2);
        p.last = (idx == 6'd3);
      end
      ACT_STOP: begin
        p.sda  = (idx == 6'd3) || (idx == 6'd4);
        p.scl  = (idx != 6'd0);
        p.last = (idx == 6'd4);
      end
      ACT_WRITE: begin
        p.sda  = idx[5] ? 1'b1 : data[bsel];
        p.scl  = mid;
        p.last = (idx == 6'd35);
        p.tag  = (idx == 6'd35) ? TAG_ACK : TAG_IGNORE;
      end
      ACT_READ: begin
        p.sda  = 1'b1;
        p.scl  = mid;
        p.last = (idx == 6'd31);
        p.tag  = (idx[1:0] == 2'd3) ? TAG_DATA : TAG_IGNORE;
      end
      ACT_ACK: begin
        p.sda  = ~ack;
        p.scl  = mid;
        p.last = (idx == 6'd3);
      end
      default: p.last = 1'b1;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/i2cbb_ram.sv =====
// generic single write port ram with registered read
module i2cbb_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/i2cbb_front.sv =====
// front end: accepts items, reserves tag slots, queues classified items
module i2cbb_front #(
  parameter int TAG_DEPTH = i2cbb_pkg::TAG_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_action,
  input  logic [7:0]        in_data_byte,
  input  logic              in_ack_level,
  input  logic              in_sda_sample,
  output i2cbb_pkg::cmdq_t  cmdq,
  input  logic              pop
);

  localparam int CW  = $clog2(TAG_DEPTH + 1);
  localparam int QAW = $clog2(i2cbb_pkg::CMDQ_DEPTH);
  localparam int QCW = $clog2(i2cbb_pkg::CMDQ_DEPTH + 1);

  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [QAW-1:0]      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0]      qcnt_r, qcnt_nxt;
  i2cbb_pkg::entry_t   q_r [i2cbb_pkg::CMDQ_DEPTH];
  i2cbb_pkg::entry_t   ent;
  logic                accept, is_smp, is_cmd, fits, push;
  logic [CW:0]         sum;

  // classify the incoming item and check tag room
  always_comb begin
    accept = in_valid && !in_stall;
    is_smp = (in_action == i2cbb_pkg::ACT_SAMPLE);
    is_cmd = (in_action <= i2cbb_pkg::ACT_ACK);
    sum    = {1'b0, cnt_r} + (CW+1)'(i2cbb_pkg::need_f(in_action));
    fits   = (sum <= (CW+1)'(TAG_DEPTH));
    push   = accept && (is_smp || is_cmd);

    ent.action = i2cbb_pkg::action_t'(in_action);
    ent.data   = in_data_byte;
    ent.ack    = in_ack_level;
    ent.sda    = in_sda_sample;
    ent.hit    = (cnt_r != '0);
    if (is_smp) begin
      ent.cls = i2cbb_pkg::CLS_SAMPLE;
    end else if (fits) begin
      ent.cls = i2cbb_pkg::CLS_CMD;
    end else begin
      ent.cls = i2cbb_pkg::CLS_REFUSE;
    end

    cnt_nxt = cnt_r;
    if (push) begin
      if (is_smp) begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end else if (fits) begin
        cnt_nxt = sum[CW-1:0];
      end
    end
  end

  // command queue pointers
  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    qcnt_nxt = qcnt_r;
    if (push) begin
      wp_nxt = (wp_r == QAW'(i2cbb_pkg::CMDQ_DEPTH - 1)) ? '0 : wp_r + QAW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == QAW'(i2cbb_pkg::CMDQ_DEPTH - 1)) ? '0 : rp_r + QAW'(1);
    end
    case ({push, pop})
      2'b10:   qcnt_nxt = qcnt_r + QCW'(1);
      2'b01:   qcnt_nxt = qcnt_r - QCW'(1);
      default: qcnt_nxt = qcnt_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      wp_r   <= '0;
      rp_r   <= '0;
      qcnt_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      qcnt_r <= qcnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= ent;
    end
  end

  assign in_stall    = (qcnt_r == QCW'(i2cbb_pkg::CMDQ_DEPTH));
  assign cmdq.valid  = (qcnt_r != '0);
  assign cmdq.entry  = q_r[rp_r];

  // reservation never exceeds the tag queue
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TAG_DEPTH))
    else $error("tag reservation count beyond depth");

endmodule

// ===== hdl/i2cbb_back.sv =====
// back end: sequences pin phases, tag queue and sample handling
module i2cbb_back #(
  parameter int TAG_DEPTH = i2cbb_pkg::TAG_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  i2cbb_pkg::cmdq_t cmdq,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_result_kind,
  output logic             out_scl_level,
  output logic             out_sda_level,
  output logic             out_last_phase,
  output logic [7:0]       out_rx_byte,
  output logic             out_rx_valid,
  output logic             out_bus_error
);

  localparam int PW = $clog2(TAG_DEPTH);

  i2cbb_pkg::bk_state_t state_r, state_nxt;
  i2cbb_pkg::entry_t    cur_r, cur_nxt;
  i2cbb_pkg::phase_t    ph;
  i2cbb_pkg::tag_t      rtag;
  logic [5:0]           idx_r, idx_nxt;
  logic [PW-1:0]        head_r, head_nxt, tail_r, tail_nxt;
  logic [2:0]           bcnt_r, bcnt_nxt;
  logic [7:0]           shift_r, shift_nxt, shifted;
  logic                 err_r, err_nxt;
  logic                 adv, ram_we, ram_re;
  logic [1:0]           ram_rdata;

  logic                 out_valid_r, out_valid_nxt;
  i2cbb_pkg::kind_t     kind_r, kind_nxt;
  logic                 scl_r, scl_nxt, sda_r, sda_nxt, last_r, last_nxt;
  logic [7:0]           rx_r, rx_nxt;
  logic                 rxv_r, rxv_nxt, berr_r, berr_nxt;

  // tag queue memory
  i2cbb_ram #(.WIDTH(2), .DEPTH(TAG_DEPTH)) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ph.tag),
    .re    (ram_re),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign adv     = !out_valid_r || !out_stall;
  assign ph      = i2cbb_pkg::phase_f(cur_r.action, cur_r.data, cur_r.ack, idx_r);
  assign rtag    = i2cbb_pkg::tag_t'(ram_rdata);
  assign shifted = {shift_r[6:0], cur_r.sda};

  // sequencer next state and result load
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    bcnt_nxt      = bcnt_r;
    shift_nxt     = shift_r;
    err_nxt       = err_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    out_valid_nxt = adv ? 1'b0 : out_valid_r;
    kind_nxt      = kind_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    last_nxt      = last_r;
    rx_nxt        = rx_r;
    rxv_nxt       = rxv_r;
    berr_nxt      = berr_r;
    case (state_r)
      i2cbb_pkg::BK_IDLE: begin
        if (cmdq.valid && adv) begin
          pop     = 1'b1;
          cur_nxt = cmdq.entry;
          case (cmdq.entry.cls)
            i2cbb_pkg::CLS_REFUSE: begin
              out_valid_nxt = 1'b1;
              kind_nxt      = i2cbb_pkg::KIND_REFUSE;
              scl_nxt       = 1'b0;
              sda_nxt       = 1'b0;
              last_nxt      = 1'b0;
              rx_nxt        = 8'd0;
              rxv_nxt       = 1'b0;
              berr_nxt      = err_r;
            end
            i2cbb_pkg::CLS_CMD: begin
              if (cmdq.entry.action == i2cbb_pkg::ACT_START) begin
                err_nxt   = 1'b0;
                bcnt_nxt  = 3'd0;
                shift_nxt = 8'd0;
              end
              idx_nxt   = 6'd0;
              state_nxt = i2cbb_pkg::BK_PHASE;
            end
            i2cbb_pkg::CLS_SAMPLE: begin
              ram_re    = 1'b1;
              state_nxt = i2cbb_pkg::BK_SAMPLE;
            end
            default: state_nxt = i2cbb_pkg::BK_IDLE;
          endcase
        end
      end
      i2cbb_pkg::BK_PHASE: begin
        if (adv) begin
          ram_we        = 1'b1;
          tail_nxt      = (tail_r == PW'(TAG_DEPTH - 1)) ? '0 : tail_r + PW'(1);
          idx_nxt       = idx_r + 6'd1;
          out_valid_nxt = 1'b1;
          kind_nxt      = i2cbb_pkg::KIND_PHASE;
          scl_nxt       = ph.scl;
          sda_nxt       = ph.sda;
          last_nxt      = ph.last;
          rx_nxt        = 8'd0;
          rxv_nxt       = 1'b0;
          berr_nxt      = err_r;
          if (ph.last) begin
            state_nxt = i2cbb_pkg::BK_IDLE;
          end
        end
      end
      i2cbb_pkg::BK_SAMPLE: begin
        if (adv) begin
          rx_nxt  = 8'd0;
          rxv_nxt = 1'b0;
          if (cur_r.hit) begin
            head_nxt = (head_r == PW'(TAG_DEPTH - 1)) ? '0 : head_r + PW'(1);
            if (rtag == i2cbb_pkg::TAG_ACK) begin
              if (cur_r.sda) begin
                err_nxt = 1'b1;
              end
            end else if (rtag == i2cbb_pkg::TAG_DATA && !err_r) begin
              if (bcnt_r == 3'(i2cbb_pkg::BYTE_BITS - 1)) begin
                rx_nxt    = shifted;
                rxv_nxt   = 1'b1;
                shift_nxt = 8'd0;
                bcnt_nxt  = 3'd0;
              end else begin
                shift_nxt = shifted;
                bcnt_nxt  = bcnt_r + 3'd1;
              end
            end
          end
          out_valid_nxt = 1'b1;
          kind_nxt      = i2cbb_pkg::KIND_SAMPLE;
          scl_nxt       = 1'b0;
          sda_nxt       = 1'b0;
          last_nxt      = 1'b0;
          berr_nxt      = err_nxt;
          state_nxt     = i2cbb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = i2cbb_pkg::BK_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= i2cbb_pkg::BK_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      bcnt_r      <= 3'd0;
      shift_r     <= 8'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      bcnt_r      <= bcnt_nxt;
      shift_r     <= shift_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    kind_r <= kind_nxt;
    scl_r  <= scl_nxt;
    sda_r  <= sda_nxt;
    last_r <= last_nxt;
    rx_r   <= rx_nxt;
    rxv_r  <= rxv_nxt;
    berr_r <= berr_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_scl_level   = scl_r;
  assign out_sda_level   = sda_r;
  assign out_last_phase  = last_r;
  assign out_rx_byte     = rx_r;
  assign out_rx_valid    = rxv_r;
  assign out_bus_error   = berr_r;

  // a completed byte only rides on a sample report
  a_rxv_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rxv_r |-> kind_r == i2cbb_pkg::KIND_SAMPLE)
    else $error("rx_valid on non-sample result");

  // the sample state is always entered from a pop in idle
  a_smp_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == i2cbb_pkg::BK_SAMPLE && $past(state_r) != i2cbb_pkg::BK_SAMPLE
    |-> $past(state_r) == i2cbb_pkg::BK_IDLE && $past(pop))
    else $error("sample state entered without pop");

  // a finished phase run returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == i2cbb_pkg::BK_PHASE && adv && ph.last |=> state_r == i2cbb_pkg::BK_IDLE)
    else $error("sequencer did not leave phase run");

endmodule

// ===== hdl/i2c_bitbang_master_phaser_unit.sv =====
// top level of the i2c bit-bang master phaser
// Usage: the in_ channel takes bus commands (start, repeated start, stop,
// write byte, read byte, ack/nack) and sample items carrying the sda level
// seen for the oldest emitted phase. The out_ channel returns one result per
// pin phase, one report per sample item and one refusal per command that
// does not fit the tag queue. Action code seven is dropped without a result.
// The front accepts an item into a four-entry command queue; the back then
// pops it and emits one pin phase per cycle while out_stall does not hold it,
// and pops no further item until the last phase of a command is emitted. A
// sample report needs a tag memory read before it is registered. With the
// back free, a refusal is registered when it is popped from the command queue;
// any other item is popped into the sequencer first and its result follows.
// The tag queue is a TAG_DEPTH entry memory; its fill is tracked by counters
// so it needs no clearing after reset. Reset clears all queue pointers, the
// byte assembly and the error flag. When out_stall is high while a result is
// valid, the result register holds and the back waits; the front keeps
// accepting items until its command queue is full, then raises in_stall.
module i2c_bitbang_master_phaser_unit #(
  parameter int TAG_DEPTH = i2cbb_pkg::TAG_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_ack_level,
  input  logic       in_sda_sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_last_phase,
  output logic [7:0] out_rx_byte,
  output logic       out_rx_valid,
  output logic       out_bus_error
);

  i2cbb_pkg::cmdq_t cmdq;
  logic             pop;

  // accept and classify
  i2cbb_front #(.TAG_DEPTH(TAG_DEPTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_data_byte  (in_data_byte),
    .in_ack_level  (in_ack_level),
    .in_sda_sample (in_sda_sample),
    .cmdq          (cmdq),
    .pop           (pop)
  );

  // phase sequencing and sample handling
  i2cbb_back #(.TAG_DEPTH(TAG_DEPTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmdq            (cmdq),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_scl_level   (out_scl_level),
    .out_sda_level   (out_sda_level),
    .out_last_phase  (out_last_phase),
    .out_rx_byte     (out_rx_byte),
    .out_rx_valid    (out_rx_valid),
    .out_bus_error   (out_bus_error)
  );

endmodule

// ===== tb/sv/tb_i2c_bitbang_master_phaser_unit.sv =====
// self-checking testbench for the i2c bit-bang master phaser unit
`timescale 1ns / 1ps

module tb_i2c_bitbang_master_phaser_unit;

  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int QDEPTH       = i2cbb_pkg::TAG_DEPTH_DEF;
  localparam int ITEM_TARGET  = 370;
  localparam int QUIET_FROM   = 310;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 40;

  // one result item as seen on the out_ channel
  typedef struct packed {
    i2cbb_pkg::kind_t kind;
    logic             scl;
    logic             sda;
    logic             last;
    logic [7:0]       rx_byte;
    logic             rx_valid;
    logic             bus_err;
  } bus_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [2:0] in_action = i2cbb_pkg::ACT_START;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_ack_level = 1'b0;
  logic       in_sda_sample = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_result_kind;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_last_phase;
  logic [7:0] out_rx_byte;
  logic       out_rx_valid;
  logic       out_bus_error;

  i2c_bitbang_master_phaser_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .in_ack_level   (in_ack_level),
    .in_sda_sample  (in_sda_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_scl_level  (out_scl_level),
    .out_sda_level  (out_sda_level),
    .out_last_phase (out_last_phase),
    .out_rx_byte    (out_rx_byte),
    .out_rx_valid   (out_rx_valid),
    .out_bus_error  (out_bus_error)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: tag fifo, byte assembly and sticky nack
  i2cbb_pkg::tag_t tag_mem [QDEPTH];
  int              tag_head = 0;
  int              tag_fill = 0;
  int              bits_in = 0;
  logic [7:0]      shift_reg = 8'd0;
  logic            nack_seen = 1'b0;
  bus_result_t     bus_results_due[$];

  // run bookkeeping
  int   fail_count = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   refusals = 0;
  int   bytes_rx = 0;
  int   nacks = 0;
  int   cycles = 0;
  logic quiet = 1'b0;
  bit   first_pass = 1'b1;

  // receiver stall control
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int run_left = 0;

  // one pin phase: queue its tag and its result
  task automatic push_phase(input logic sda, input logic scl, input i2cbb_pkg::tag_t tag,
                            input logic last);
    bus_result_t r;
    r = '0;
    tag_mem[(tag_head + tag_fill) % QDEPTH] = tag;
    tag_fill++;
    r.kind    = i2cbb_pkg::KIND_PHASE;
    r.scl     = scl;
    r.sda     = sda;
    r.last    = last;
    r.bus_err = nack_seen;
    bus_results_due.push_back(r);
  endtask

  // one bus bit: low, high, high, low with the tag on the closing phase
  task automatic push_bit_cycle(input logic s, input i2cbb_pkg::tag_t tag_end,
                                input logic last);
    push_phase(s, 1'b0, i2cbb_pkg::TAG_IGNORE, 1'b0);
    push_phase(s, 1'b1, i2cbb_pkg::TAG_IGNORE, 1'b0);
    push_phase(s, 1'b1, i2cbb_pkg::TAG_IGNORE, 1'b0);
    push_phase(s, 1'b0, tag_end, last);
  endtask

  // work out the results that one accepted item causes
  task automatic derive_bus_results(input logic [2:0] act, input logic [7:0] data,
                                    input logic ack, input logic sda);
    bus_result_t     r;
    i2cbb_pkg::tag_t t;
    int              need;
    int              i;
    r = '0;
    need = 0;
    case (act)
      i2cbb_pkg::ACT_START:  need = 3;
      i2cbb_pkg::ACT_RSTART: need = 4;
      i2cbb_pkg::ACT_STOP:   need = 5;
      i2cbb_pkg::ACT_WRITE:  need = 36;
      i2cbb_pkg::ACT_READ:   need = 32;
      i2cbb_pkg::ACT_ACK:    need = 4;
      default:               need = 0;
    endcase
    if (act == i2cbb_pkg::ACT_SAMPLE) begin
      // pop the oldest tag and apply the sampled level
      if (tag_fill != 0) begin
        t = tag_mem[tag_head];
        tag_head = (tag_head + 1) % QDEPTH;
        tag_fill--;
        if (t == i2cbb_pkg::TAG_ACK) begin
          if (sda) begin
            nack_seen = 1'b1;
            nacks++;
          end
        end else if (t == i2cbb_pkg::TAG_DATA && !nack_seen) begin
          shift_reg = {shift_reg[6:0], sda};
          if (bits_in == i2cbb_pkg::BYTE_BITS - 1) begin
            r.rx_byte  = shift_reg;
            r.rx_valid = 1'b1;
            shift_reg  = 8'd0;
            bits_in    = 0;
            bytes_rx++;
          end else begin
            bits_in++;
          end
        end
      end
      r.kind    = i2cbb_pkg::KIND_SAMPLE;
      r.bus_err = nack_seen;
      bus_results_due.push_back(r);
    end else if (need != 0) begin
      if (QDEPTH - tag_fill < need) begin
        // not enough tag slots: one refusal and no state change
        r.kind    = i2cbb_pkg::KIND_REFUSE;
        r.bus_err = nack_seen;
        bus_results_due.push_back(r);
        refusals++;
      end else begin
        case (act)
          i2cbb_pkg::ACT_START: begin
            bits_in   = 0;
            shift_reg = 8'd0;
            nack_seen = 1'b0;
            push_phase(1'b0, 1'b1, i2cbb_pkg::TAG_IGNORE, 1'b0);
            push_phase(1'b0, 1'b1, i2cbb_pkg::TAG_IGNORE, 1'b0);
            push_phase(1'b0, 1'b0, i2cbb_pkg::TAG_IGNORE, 1'b1);
          end
          i2cbb_pkg::ACT_RSTART: begin
            push_phase(1'b1, 1'b0, i2cbb_pkg::TAG_IGNORE, 1'b0);
            push_phase(1'b1, 1'b1, i2cbb_pkg::TAG_IGNORE, 1'b0);
            push_phase(1'b0, 1'b1, i2cbb_pkg::TAG_IGNORE, 1'b0);
            push_phase(1'b0, 1'b0, i2cbb_pkg::TAG_IGNORE, 1'b1);
          end
          i2cbb_pkg::ACT_STOP: begin
            push_phase(1'b0, 1'b0, i2cbb_pkg::TAG_IGNORE, 1'b0);
            push_phase(1'b0, 1'b1, i2cbb_pkg::TAG_IGNORE, 1'b0);
            push_phase(1'b0, 1'b1, i2cbb_pkg::TAG_IGNORE, 1'b0);
            push_phase(1'b1, 1'b1, i2cbb_pkg::TAG_IGNORE, 1'b0);
            push_phase(1'b1, 1'b1, i2cbb_pkg::TAG_IGNORE, 1'b1);
          end
          i2cbb_pkg::ACT_WRITE: begin
            for (i = i2cbb_pkg::BYTE_BITS - 1; i >= 0; i--)
              push_bit_cycle(data[i], i2cbb_pkg::TAG_IGNORE, 1'b0);
            push_bit_cycle(1'b1, i2cbb_pkg::TAG_ACK, 1'b1);
          end
          i2cbb_pkg::ACT_READ: begin
            for (i = 0; i < i2cbb_pkg::BYTE_BITS; i++)
              push_bit_cycle(1'b1, i2cbb_pkg::TAG_DATA, i == i2cbb_pkg::BYTE_BITS - 1);
          end
          default: push_bit_cycle(~ack, i2cbb_pkg::TAG_IGNORE, 1'b1);
        endcase
      end
    end
  endtask

  // offer one item, optionally after an idle burst, and wait for acceptance
  task automatic send_item(input logic [2:0] act, input logic [7:0] data,
                           input logic ack, input logic sda);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_data_byte  <= data;
    in_ack_level  <= ack;
    in_sda_sample <= sda;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    derive_bus_results(act, data, ack, sda);
    if (act != ACT_UNUSED) items_sent++;
    if (!quiet && items_sent >= QUIET_FROM) quiet <= 1'b1;
  endtask

  // return samples until no tag is left
  task automatic drain_tags;
    while (tag_fill != 0)
      send_item(i2cbb_pkg::ACT_SAMPLE, 8'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  // samples for a run of n phases, sometimes cut short
  task automatic sample_run(input int n, input bit write_ack, input logic ack_val);
    int   cut;
    int   i;
    logic s;
    cut = n;
    if (!first_pass && $urandom_range(0, 11) == 0) cut = $urandom_range(0, n - 1);
    for (i = 0; i < cut; i++) begin
      s = (write_ack && i == n - 1) ? ack_val : 1'($urandom_range(0, 1));
      send_item(i2cbb_pkg::ACT_SAMPLE, 8'($urandom), 1'($urandom_range(0, 1)), s);
    end
  endtask

  // occasional stray item of any action
  task automatic maybe_noise;
    if ($urandom_range(0, 6) == 0)
      send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  // sample reports with nothing queued
  task automatic test_empty_queue_sample;
    send_item(i2cbb_pkg::ACT_SAMPLE, 8'h00, 1'b0, 1'b0);
    send_item(i2cbb_pkg::ACT_SAMPLE, 8'hFF, 1'b1, 1'b1);
  endtask

  // action code seven gives no result
  task automatic test_unused_action;
    send_item(ACT_UNUSED, 8'hFF, 1'b1, 1'b1);
  endtask

  // every command at least once, then fill the tag queue until commands are refused
  task automatic test_commands_and_refusal;
    send_item(i2cbb_pkg::ACT_START, 8'h5A, 1'b1, 1'b0);
    send_item(i2cbb_pkg::ACT_RSTART, 8'hA5, 1'b0, 1'b1);
    send_item(i2cbb_pkg::ACT_STOP, 8'h00, 1'b1, 1'b0);
    send_item(i2cbb_pkg::ACT_WRITE, 8'h00, 1'b0, 1'b1);
    send_item(i2cbb_pkg::ACT_ACK, 8'h00, 1'b1, 1'b0);
    send_item(i2cbb_pkg::ACT_ACK, 8'hFF, 1'b0, 1'b0);
    send_item(i2cbb_pkg::ACT_READ, 8'h00, 1'b0, 1'b0);
    send_item(i2cbb_pkg::ACT_WRITE, 8'hFF, 1'b1, 1'b1);
    send_item(i2cbb_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0);
    send_item(i2cbb_pkg::ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(i2cbb_pkg::ACT_ACK, 8'h00, 1'b1, 1'b1);
    drain_tags();
  endtask

  // long receiver hold while commands keep coming, so the input stalls
  task automatic test_back_pressure;
    hold_req <= hold_req + 1;
    send_item(i2cbb_pkg::ACT_START, 8'h00, 1'b0, 1'b0);
    send_item(i2cbb_pkg::ACT_WRITE, 8'hFF, 1'b0, 1'b0);
    send_item(i2cbb_pkg::ACT_ACK, 8'h00, 1'b1, 1'b0);
    send_item(i2cbb_pkg::ACT_RSTART, 8'h00, 1'b0, 1'b0);
    send_item(i2cbb_pkg::ACT_ACK, 8'h00, 1'b0, 1'b0);
    send_item(i2cbb_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0);
    send_item(i2cbb_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0);
    drain_tags();
  endtask

  // random well-formed transfers with stray items and cut-short sample runs
  task automatic test_random_transfers;
    int         nseg;
    int         seg;
    bit         do_write;
    logic [7:0] b;
    logic       nack;
    while (items_sent < ITEM_TARGET) begin
      maybe_noise();
      send_item(i2cbb_pkg::ACT_START, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
      sample_run(3, 1'b0, 1'b0);
      nseg = first_pass ? 2 : $urandom_range(1, 3);
      for (seg = 0; seg < nseg; seg++) begin
        // first transfer: nacked write, then a read that must be ignored
        do_write = first_pass ? (seg == 0) : bit'($urandom_range(0, 1));
        if (do_write) begin
          case ($urandom_range(0, 9))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
          endcase
          nack = first_pass ? 1'b1 : ($urandom_range(0, 7) == 0);
          send_item(i2cbb_pkg::ACT_WRITE, b, 1'($urandom_range(0, 1)), 1'b0);
          sample_run(36, 1'b1, nack);
        end else begin
          send_item(i2cbb_pkg::ACT_READ, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
          sample_run(32, 1'b0, 1'b0);
          send_item(i2cbb_pkg::ACT_ACK, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
          sample_run(4, 1'b0, 1'b0);
        end
        maybe_noise();
        if (seg != nseg - 1 && $urandom_range(0, 2) == 0) begin
          send_item(i2cbb_pkg::ACT_RSTART, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
          sample_run(4, 1'b0, 1'b0);
        end
      end
      send_item(i2cbb_pkg::ACT_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
      sample_run(5, 1'b0, 1'b0);
      drain_tags();
      first_pass = 1'b0;
    end
  endtask

  // receiver stall: long hold on request, else random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      run_left  <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
      run_left  <= quiet ? 0 : $urandom_range(0, 20);
    end
  end

  // compare one field and report every mismatch
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    bus_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_results_due.size() == 0) begin
        $display("%0t unexpected result: expected none actual kind %0d",
                 $time, out_result_kind);
        fail_count++;
      end else begin
        want = bus_results_due.pop_front();
        check_field("result_kind", want.kind, out_result_kind);
        check_field("scl_level", want.scl, out_scl_level);
        check_field("sda_level", want.sda, out_sda_level);
        check_field("last_phase", want.last, out_last_phase);
        check_field("rx_byte", want.rx_byte, out_rx_byte);
        check_field("rx_valid", want.rx_valid, out_rx_valid);
        check_field("bus_error", want.bus_err, out_bus_error);
        results_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("i2c_bitbang_master_phaser_unit verification failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_empty_queue_sample();
    test_unused_action();
    test_commands_and_refusal();
    test_back_pressure();
    test_random_transfers();
    in_valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d items and %0d checked results across all commands",
             items_sent, results_checked);
    $display("including %0d refusals, %0d nacked writes and %0d received bytes",
             refusals, nacks, bytes_rx);
    if (fail_count == 0) begin
      $display("i2c_bitbang_master_phaser_unit verification clean");
    end else begin
      $display("i2c_bitbang_master_phaser_unit verification failed");
    end
    $finish;
  end

endmodule
